/* rtl/hrp_pkg.sv */
// Shared types, constants and character helpers for the HTTP request parser.
package hrp_pkg;

  localparam int unsigned HEAD_LEN_W = 16;
  localparam int unsigned BODY_LEN_W = 24;
  localparam int unsigned HEAD_CNT_W = 17;
  localparam int unsigned BODY_CNT_W = 25;
  localparam int unsigned CFG_DATA_W = 24;

  localparam logic [HEAD_LEN_W-1:0] HEAD_LIMIT_RST = 16'd8192;
  localparam logic [BODY_LEN_W-1:0] BODY_LIMIT_RST = 24'd65536;

  localparam logic [BODY_CNT_W-1:0] SAT25 = 25'h1FF_FFFF;
  localparam logic [HEAD_CNT_W-1:0] HEAD_SAT = 17'h1_FFFF;

  // method match: 0..4 progress through "POST", FAIL once it diverges
  localparam logic [2:0] MM_FULL = 3'd4;
  localparam logic [2:0] MM_FAIL = 3'd5;
  // header name match: 0..14 progress through "content-length"
  localparam logic [4:0] NM_FULL = 5'd14;
  localparam logic [4:0] NM_FAIL = 5'd31;

  // Content-Length value reader phases
  localparam logic [1:0] VP_SKIP = 2'd0;
  localparam logic [1:0] VP_POS  = 2'd1;
  localparam logic [1:0] VP_NEG  = 2'd2;
  localparam logic [1:0] VP_END  = 2'd3;

  // configuration register indexes
  localparam logic CFG_MAX_HEAD = 1'b0;
  localparam logic CFG_MAX_BODY = 1'b1;

  typedef enum logic [4:0] {
    S_METHOD_START = 5'd0,
    S_METHOD       = 5'd1,
    S_URI          = 5'd2,
    S_H            = 5'd3,
    S_T1           = 5'd4,
    S_T2           = 5'd5,
    S_P            = 5'd6,
    S_SLASH        = 5'd7,
    S_MAJ_START    = 5'd8,
    S_MAJ          = 5'd9,
    S_MIN_START    = 5'd10,
    S_MIN          = 5'd11,
    S_NL1          = 5'd12,
    S_LINE_START   = 5'd13,
    S_LWS          = 5'd14,
    S_NAME         = 5'd15,
    S_SP_VALUE     = 5'd16,
    S_VALUE        = 5'd17,
    S_NL2          = 5'd18,
    S_NL3          = 5'd19,
    S_BODY         = 5'd20,
    S_DONE         = 5'd21
  } parse_state_t;

  typedef enum logic [1:0] {
    ST_NEED     = 2'd0,
    ST_COMPLETE = 2'd1,
    ST_BAD      = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    CLS_SYNTAX     = 3'd0,
    CLS_METHOD     = 3'd1,
    CLS_URI        = 3'd2,
    CLS_NAME_FIRST = 3'd3,
    CLS_NAME       = 3'd4,
    CLS_VALUE      = 3'd5,
    CLS_BODY       = 3'd6
  } byte_class_t;

  typedef struct packed {
    status_t                 parse_status;
    byte_class_t             byte_class;
    logic [3:0]              minor_version;
    logic                    is_post;
    logic [BODY_LEN_W-1:0]   declared_length;
  } hrp_result_t;

  function automatic logic is_ctl(input logic [7:0] b);
    return (b < 8'd32) || (b == 8'd127);
  endfunction

  function automatic logic is_special(input logic [7:0] b);
    logic r;
    unique case (b)
      "(", ")", "<", ">", "@", ",", ";", ":", "\\", "\"",
      "/", "[", "]", "?", "=", "{", "}", " ", 8'h09: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic is_token(input logic [7:0] b);
    return !b[7] && !is_ctl(b) && !is_special(b);
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] b);
    return (b >= "A" && b <= "Z") ? (b + 8'd32) : b;
  endfunction

  function automatic logic [7:0] post_char(input logic [1:0] idx);
    logic [7:0] c;
    unique case (idx)
      2'd0: c = "P";
      2'd1: c = "O";
      2'd2: c = "S";
      2'd3: c = "T";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] cl_char(input logic [3:0] idx);
    logic [7:0] c;
    unique case (idx)
      4'd0:  c = "c";
      4'd1:  c = "o";
      4'd2:  c = "n";
      4'd3:  c = "t";
      4'd4:  c = "e";
      4'd5:  c = "n";
      4'd6:  c = "t";
      4'd7:  c = "-";
      4'd8:  c = "l";
      4'd9:  c = "e";
      4'd10: c = "n";
      4'd11: c = "g";
      4'd12: c = "t";
      4'd13: c = "h";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

/* rtl/hrp_core.sv */
// Parser state registers and the per-byte next-state and result logic.
module hrp_core
  import hrp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  advance,
  input  logic                  new_request,
  input  logic [7:0]            in_byte,
  input  logic [HEAD_LEN_W-1:0] head_limit,
  input  logic [BODY_LEN_W-1:0] body_limit,
  output hrp_result_t           result
);

  typedef struct packed {
    logic [BODY_CNT_W-1:0] length_value;
    logic [1:0]            value_phase;
  } value_acc_t;

  parse_state_t          parse_state, parse_state_next, cur_state;
  logic [HEAD_CNT_W-1:0] head_count, head_count_next, cur_head;
  logic [BODY_CNT_W-1:0] body_count, body_count_next, cur_body;
  logic [BODY_CNT_W-1:0] length_value, length_value_next, cur_len;
  logic [2:0]            method_match, method_match_next, cur_mm;
  logic                  header_seen, header_seen_next, cur_seen;
  logic [4:0]            name_match, name_match_next, cur_nm;
  logic                  len_found, len_found_next, cur_found;
  logic                  len_collect, len_collect_next, cur_collect;
  logic [1:0]            value_phase, value_phase_next, cur_vp;
  logic [3:0]            version_minor, version_minor_next, cur_minor;
  status_t               final_status, final_status_next, cur_final;

  status_t               res;
  byte_class_t           cls;
  value_acc_t            fed;
  logic [BODY_CNT_W-1:0] end_len;
  logic                  is_space;

  // atol-style accumulation of the Content-Length value
  function automatic value_acc_t feed_value(input logic [BODY_CNT_W-1:0] lv,
                                            input logic [1:0] vp,
                                            input logic collect,
                                            input logic [7:0] b);
    value_acc_t r;
    logic [BODY_CNT_W+3:0] v;
    r.length_value = lv;
    r.value_phase  = vp;
    v = {lv, 3'b000} + {2'b00, lv, 1'b0} + {{(BODY_CNT_W){1'b0}}, b[3:0]};
    if (collect && vp != VP_END) begin
      if (b >= "0" && b <= "9") begin
        r.length_value = (v > {4'b0000, SAT25}) ? SAT25 : v[BODY_CNT_W-1:0];
        if (vp == VP_SKIP) r.value_phase = VP_POS;
      end else if (vp == VP_SKIP && b == " ") begin
        r.value_phase = vp;
      end else if (vp == VP_SKIP && b == "+") begin
        r.value_phase = VP_POS;
      end else if (vp == VP_SKIP && b == "-") begin
        r.value_phase = VP_NEG;
      end else begin
        r.value_phase = VP_END;
      end
    end
    return r;
  endfunction

  always_comb begin
    // new_request clears everything before the byte is taken
    cur_state   = new_request ? S_METHOD_START : parse_state;
    cur_head    = new_request ? '0 : head_count;
    cur_body    = new_request ? '0 : body_count;
    cur_len     = new_request ? '0 : length_value;
    cur_mm      = new_request ? '0 : method_match;
    cur_seen    = new_request ? 1'b0 : header_seen;
    cur_nm      = new_request ? '0 : name_match;
    cur_found   = new_request ? 1'b0 : len_found;
    cur_collect = new_request ? 1'b0 : len_collect;
    cur_vp      = new_request ? VP_SKIP : value_phase;
    cur_minor   = new_request ? '0 : version_minor;
    cur_final   = new_request ? ST_NEED : final_status;

    parse_state_next   = cur_state;
    head_count_next    = cur_head;
    body_count_next    = cur_body;
    length_value_next  = cur_len;
    method_match_next  = cur_mm;
    header_seen_next   = cur_seen;
    name_match_next    = cur_nm;
    len_found_next     = cur_found;
    len_collect_next   = cur_collect;
    value_phase_next   = cur_vp;
    version_minor_next = cur_minor;
    final_status_next  = cur_final;

    res      = cur_final;
    cls      = CLS_SYNTAX;
    fed      = feed_value(cur_len, cur_vp, cur_collect, in_byte);
    end_len  = cur_found ? cur_len : '0;
    is_space = (in_byte == " ") || (in_byte == 8'h09);

    if (cur_final == ST_NEED) begin
      if (cur_state != S_BODY) begin
        head_count_next = (cur_head == HEAD_SAT) ? cur_head : cur_head + 1'b1;
        if (head_count_next > {1'b0, head_limit}) res = ST_BAD;
      end
      if (res == ST_NEED) begin
        unique case (cur_state)
          S_METHOD_START: begin
            if (!is_token(in_byte)) res = ST_BAD;
            else begin
              method_match_next = (in_byte == "P") ? 3'd1 : MM_FAIL;
              parse_state_next  = S_METHOD;
              cls = CLS_METHOD;
            end
          end
          S_METHOD: begin
            if (in_byte == " ") parse_state_next = S_URI;
            else if (!is_token(in_byte)) res = ST_BAD;
            else begin
              if (cur_mm < MM_FULL && in_byte == post_char(cur_mm[1:0]))
                method_match_next = cur_mm + 3'd1;
              else
                method_match_next = MM_FAIL;
              cls = CLS_METHOD;
            end
          end
          S_URI: begin
            if (in_byte == " ") parse_state_next = S_H;
            else if (is_ctl(in_byte)) res = ST_BAD;
            else cls = CLS_URI;
          end
          S_H: begin
            if (in_byte != "H") res = ST_BAD;
            else parse_state_next = S_T1;
          end
          S_T1: begin
            if (in_byte != "T") res = ST_BAD;
            else parse_state_next = S_T2;
          end
          S_T2: begin
            if (in_byte != "T") res = ST_BAD;
            else parse_state_next = S_P;
          end
          S_P: begin
            if (in_byte != "P") res = ST_BAD;
            else parse_state_next = S_SLASH;
          end
          S_SLASH: begin
            if (in_byte != "/") res = ST_BAD;
            else begin
              version_minor_next = '0;
              parse_state_next   = S_MAJ_START;
            end
          end
          S_MAJ_START: begin
            if (in_byte != "1") res = ST_BAD;
            else parse_state_next = S_MAJ;
          end
          S_MAJ: begin
            if (in_byte != ".") res = ST_BAD;
            else parse_state_next = S_MIN_START;
          end
          S_MIN_START: begin
            if (in_byte < "0" || in_byte > "9") res = ST_BAD;
            else begin
              version_minor_next = in_byte[3:0];
              parse_state_next   = S_MIN;
            end
          end
          S_MIN: begin
            if (in_byte != 8'h0D) res = ST_BAD;
            else parse_state_next = S_NL1;
          end
          S_NL1: begin
            if (in_byte != 8'h0A) res = ST_BAD;
            else parse_state_next = S_LINE_START;
          end
          S_LINE_START: begin
            if (in_byte == 8'h0D) parse_state_next = S_NL3;
            else if (cur_seen && is_space) parse_state_next = S_LWS;
            else if (!is_token(in_byte)) res = ST_BAD;
            else begin
              header_seen_next = 1'b1;
              len_collect_next = 1'b0;
              name_match_next  = (!cur_found && to_lower(in_byte) == "c") ? 5'd1 : NM_FAIL;
              parse_state_next = S_NAME;
              cls = CLS_NAME_FIRST;
            end
          end
          S_LWS: begin
            if (in_byte == 8'h0D) parse_state_next = S_NL2;
            else if (is_space) parse_state_next = S_LWS;
            else if (is_ctl(in_byte)) res = ST_BAD;
            else begin
              length_value_next = fed.length_value;
              value_phase_next  = fed.value_phase;
              parse_state_next  = S_VALUE;
              cls = CLS_VALUE;
            end
          end
          S_NAME: begin
            if (in_byte == ":") begin
              if (cur_nm == NM_FULL && !cur_found) begin
                len_found_next    = 1'b1;
                len_collect_next  = 1'b1;
                value_phase_next  = VP_SKIP;
                length_value_next = '0;
              end
              parse_state_next = S_SP_VALUE;
            end else if (!is_token(in_byte)) res = ST_BAD;
            else begin
              if (cur_nm < NM_FULL && to_lower(in_byte) == cl_char(cur_nm[3:0]))
                name_match_next = cur_nm + 5'd1;
              else
                name_match_next = NM_FAIL;
              cls = CLS_NAME;
            end
          end
          S_SP_VALUE: begin
            if (in_byte != " ") res = ST_BAD;
            else parse_state_next = S_VALUE;
          end
          S_VALUE: begin
            if (in_byte == 8'h0D) parse_state_next = S_NL2;
            else if (is_ctl(in_byte)) res = ST_BAD;
            else begin
              length_value_next = fed.length_value;
              value_phase_next  = fed.value_phase;
              cls = CLS_VALUE;
            end
          end
          S_NL2: begin
            if (in_byte != 8'h0A) res = ST_BAD;
            else parse_state_next = S_LINE_START;
          end
          S_NL3: begin
            if (in_byte != 8'h0A) res = ST_BAD;
            else if (cur_mm == MM_FULL) begin
              if (cur_vp == VP_NEG && end_len != '0) res = ST_BAD;
              else if (end_len > {1'b0, body_limit}) res = ST_BAD;
              else begin
                length_value_next = end_len;
                if (end_len == '0) begin
                  parse_state_next = S_DONE;
                  res = ST_COMPLETE;
                end else begin
                  parse_state_next = S_BODY;
                end
              end
            end else begin
              length_value_next = '0;
              parse_state_next  = S_DONE;
              res = ST_COMPLETE;
            end
          end
          S_BODY: begin
            body_count_next = (cur_body == SAT25) ? cur_body : cur_body + 1'b1;
            if (body_count_next > {1'b0, body_limit}) res = ST_BAD;
            else begin
              cls = CLS_BODY;
              if (body_count_next == cur_len) res = ST_COMPLETE;
            end
          end
          default: res = ST_BAD;
        endcase
      end
      if (res == ST_BAD) cls = CLS_SYNTAX;
      final_status_next = res;
    end

    result.parse_status    = res;
    result.byte_class      = cls;
    result.minor_version   = version_minor_next;
    result.is_post         = (method_match_next == MM_FULL) && (parse_state_next >= S_URI);
    result.declared_length = (parse_state_next == S_BODY || parse_state_next == S_DONE) ?
                             length_value_next[BODY_LEN_W-1:0] : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_state   <= S_METHOD_START;
      head_count    <= '0;
      body_count    <= '0;
      length_value  <= '0;
      method_match  <= '0;
      header_seen   <= 1'b0;
      name_match    <= '0;
      len_found     <= 1'b0;
      len_collect   <= 1'b0;
      value_phase   <= VP_SKIP;
      version_minor <= '0;
      final_status  <= ST_NEED;
    end else if (advance) begin
      parse_state   <= parse_state_next;
      head_count    <= head_count_next;
      body_count    <= body_count_next;
      length_value  <= length_value_next;
      method_match  <= method_match_next;
      header_seen   <= header_seen_next;
      name_match    <= name_match_next;
      len_found     <= len_found_next;
      len_collect   <= len_collect_next;
      value_phase   <= value_phase_next;
      version_minor <= version_minor_next;
      final_status  <= final_status_next;
    end
  end

endmodule

/* rtl/http_request_parser.sv */
// Top level of the byte-serial HTTP request parser: ports, item registers, config.
//
//  channel | dir | handshake          | payload
//  s_      | in  | s_tvalid/s_tready  | tdata: in_byte; tuser: new_request
//  m_      | out | m_tvalid/m_tready  | tdata: status, byte, minor, post, length;
//          |     |                    | tuser: byte_class
//  cfg_    | in  | cfg_we             | cfg_index, cfg_data
//
// One item per cycle sustained while m_tready is high; each item passes the input register, then the result register.
// The input register feeds the parser step logic, which loads state and result together.
// rst clears the parser state and both valid flags and restores register defaults.
// A stalled result holds in the output register while one more item waits in the
// input register; s_tready drops only when both are full.
module http_request_parser
  import hrp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [7:0]            s_tdata,   // [7:0] in_byte
  input  logic [0:0]            s_tuser,   // [0] new_request
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // [1:0] parse_status, [9:2] out_byte, [13:10] minor_version, [14] is_post,
  // [38:15] declared_length, [39] zero
  output logic [39:0]           m_tdata,
  output logic [2:0]            m_tuser,   // [2:0] byte_class
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic                  in_valid;
  logic                  in_new;
  logic [7:0]            in_byte;
  logic                  out_valid;
  logic [39:0]           out_data;
  logic [2:0]            out_user;
  logic [HEAD_LEN_W-1:0] head_limit;
  logic [BODY_LEN_W-1:0] body_limit;
  logic                  advance;
  hrp_result_t           result;

  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;
  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;
  assign m_tuser  = out_user;

  hrp_core u_core (
    .clk          (clk),
    .rst          (rst),
    .advance      (advance),
    .new_request  (in_new),
    .in_byte      (in_byte),
    .head_limit   (head_limit),
    .body_limit   (body_limit),
    .result       (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      head_limit <= HEAD_LIMIT_RST;
      body_limit <= BODY_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MAX_HEAD: head_limit <= cfg_data[HEAD_LEN_W-1:0];
        CFG_MAX_BODY: body_limit <= cfg_data[BODY_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_new  <= s_tuser[0];
      in_byte <= s_tdata;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= {1'b0, result.declared_length, result.is_post, result.minor_version,
                   in_byte, result.parse_status};
      out_user <= result.byte_class;
    end
  end

  a_advance_gives_result: assert property (@(posedge clk) disable iff (rst)
    advance |=> m_tvalid)
    else $error("parser step did not load a result");

  a_waiting_item_holds: assert property (@(posedge clk) disable iff (rst)
    in_valid && !advance |=> in_valid && $stable(in_byte) && $stable(in_new))
    else $error("waiting input item lost or changed");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[1:0] != 2'd3 && m_tuser != 3'd7 && m_tdata[39] == 1'b0)
    else $error("result carries an undefined code");

  a_bad_is_syntax: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[1:0] == ST_BAD |-> m_tuser == CLS_SYNTAX)
    else $error("malformed byte carries a class");

endmodule

/* dv/tb.sv */
// Testbench for the HTTP request parser: predicts every result item byte by byte and checks it.
module tb;
  import hrp_pkg::*;

  localparam logic [24:0] LEN_SAT      = 25'h1FF_FFFF;
  localparam logic [16:0] HEAD_CNT_TOP = 17'h1_FFFF;
  localparam logic [31:0] POST_TEXT    = "POST";
  localparam logic [111:0] LEN_TEXT    = "content-length";

  typedef struct packed {
    status_t     st;
    byte_class_t cls;
    logic [7:0]  echo;
    logic [3:0]  minor;
    logic        post;
    logic [23:0] length;
  } parse_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'd0;   // [7:0] in_byte
  logic [0:0]  s_tuser = 1'b0;   // [0] new_request
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  // [1:0] parse_status, [9:2] out_byte, [13:10] minor_version, [14] is_post,
  // [38:15] declared_length, [39] zero
  logic [39:0] m_tdata;
  logic [2:0]  m_tuser;          // [2:0] byte_class
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  http_request_parser dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // parser copy
  parse_state_t pst;
  logic [16:0]  head_cnt;
  logic [24:0]  body_cnt, len_val;
  logic [2:0]   post_match;
  logic         hdr_seen, len_found, len_collect;
  logic [4:0]   name_pos;
  logic [1:0]   val_phase;
  logic [3:0]   minor_seen;
  status_t      final_st;
  logic [15:0]  lim_head;
  logic [23:0]  lim_body;

  parse_result_t pending_results[$];
  logic [7:0]    req[$];
  int unsigned   mismatches = 0;
  int unsigned   bytes_sent = 0;
  bit            tx_idle = 1'b0;
  bit            rx_idle = 1'b0;
  int unsigned   stall_left = 0;
  string         token_chars = "abcXYZ019!#$%&'*+-.^_|~";

  function automatic bit ctl_char(input logic [7:0] b);
    return b < 8'd32 || b == 8'd127;
  endfunction

  function automatic bit tok_char(input logic [7:0] b);
    bit sep;
    case (b)
      "(", ")", "<", ">", "@", ",", ";", ":", "\\", "\"",
      "/", "[", "]", "?", "=", "{", "}", " ", 8'h09: sep = 1'b1;
      default: sep = 1'b0;
    endcase
    return b < 8'd128 && !ctl_char(b) && !sep;
  endfunction

  function automatic logic [7:0] fold_case(input logic [7:0] b);
    return (b >= "A" && b <= "Z") ? b + 8'd32 : b;
  endfunction

  function automatic void clear_parser();
    pst = S_METHOD_START;
    head_cnt = '0; body_cnt = '0; len_val = '0;
    post_match = '0; hdr_seen = 1'b0; name_pos = '0;
    len_found = 1'b0; len_collect = 1'b0; val_phase = VP_SKIP;
    minor_seen = '0; final_st = ST_NEED;
  endfunction

  // atol-style accumulation of the Content-Length value
  function automatic void feed_length(input logic [7:0] b);
    int unsigned acc;
    if (!len_collect || val_phase == VP_END) return;
    if (b >= "0" && b <= "9") begin
      acc = 32'(len_val) * 32'd10 + 32'(b) - 32'd48;
      len_val = (len_val > LEN_SAT / 10 || acc > 32'(LEN_SAT)) ? LEN_SAT : acc[24:0];
      if (val_phase == VP_SKIP) val_phase = VP_POS;
    end else if (val_phase == VP_SKIP && b == " ") begin
    end else if (val_phase == VP_SKIP && b == "+") begin
      val_phase = VP_POS;
    end else if (val_phase == VP_SKIP && b == "-") begin
      val_phase = VP_NEG;
    end else begin
      val_phase = VP_END;
    end
  endfunction

  function automatic status_t parse_byte(input logic [7:0] b, output byte_class_t cls);
    logic [24:0] v;
    cls = CLS_SYNTAX;
    if (pst != S_BODY) begin
      if (head_cnt != HEAD_CNT_TOP) head_cnt = head_cnt + 1'b1;
      if (head_cnt > lim_head) return ST_BAD;
    end
    case (pst)
      S_METHOD_START: begin
        if (!tok_char(b)) return ST_BAD;
        post_match = (b == "P") ? 3'd1 : MM_FAIL;
        pst = S_METHOD;
        cls = CLS_METHOD;
      end
      S_METHOD: begin
        if (b == " ") begin
          pst = S_URI;
        end else begin
          if (!tok_char(b)) return ST_BAD;
          if (post_match < MM_FULL && b == POST_TEXT[8*(3-post_match[1:0]) +: 8])
            post_match = post_match + 1'b1;
          else
            post_match = MM_FAIL;
          cls = CLS_METHOD;
        end
      end
      S_URI: begin
        if (b == " ") begin
          pst = S_H;
        end else begin
          if (ctl_char(b)) return ST_BAD;
          cls = CLS_URI;
        end
      end
      S_H: begin
        if (b != "H") return ST_BAD;
        pst = S_T1;
      end
      S_T1: begin
        if (b != "T") return ST_BAD;
        pst = S_T2;
      end
      S_T2: begin
        if (b != "T") return ST_BAD;
        pst = S_P;
      end
      S_P: begin
        if (b != "P") return ST_BAD;
        pst = S_SLASH;
      end
      S_SLASH: begin
        if (b != "/") return ST_BAD;
        minor_seen = '0;
        pst = S_MAJ_START;
      end
      S_MAJ_START: begin
        if (b != "1") return ST_BAD;
        pst = S_MAJ;
      end
      S_MAJ: begin
        if (b != ".") return ST_BAD;
        pst = S_MIN_START;
      end
      S_MIN_START: begin
        if (b < "0" || b > "9") return ST_BAD;
        minor_seen = 4'(b - "0");
        pst = S_MIN;
      end
      S_MIN: begin
        if (b != 8'h0D) return ST_BAD;
        pst = S_NL1;
      end
      S_NL1: begin
        if (b != 8'h0A) return ST_BAD;
        pst = S_LINE_START;
      end
      S_LINE_START: begin
        if (b == 8'h0D) begin
          pst = S_NL3;
        end else if (hdr_seen && (b == " " || b == 8'h09)) begin
          pst = S_LWS;
        end else begin
          if (!tok_char(b)) return ST_BAD;
          hdr_seen = 1'b1;
          len_collect = 1'b0;
          name_pos = (!len_found && fold_case(b) == "c") ? 5'd1 : NM_FAIL;
          pst = S_NAME;
          cls = CLS_NAME_FIRST;
        end
      end
      S_LWS: begin
        if (b == 8'h0D) begin
          pst = S_NL2;
        end else if (b != " " && b != 8'h09) begin
          if (ctl_char(b)) return ST_BAD;
          feed_length(b);
          pst = S_VALUE;
          cls = CLS_VALUE;
        end
      end
      S_NAME: begin
        if (b == ":") begin
          if (name_pos == NM_FULL && !len_found) begin
            len_found = 1'b1;
            len_collect = 1'b1;
            val_phase = VP_SKIP;
            len_val = '0;
          end
          pst = S_SP_VALUE;
        end else begin
          if (!tok_char(b)) return ST_BAD;
          if (name_pos < NM_FULL && fold_case(b) == LEN_TEXT[8*(13-name_pos) +: 8])
            name_pos = name_pos + 1'b1;
          else
            name_pos = NM_FAIL;
          cls = CLS_NAME;
        end
      end
      S_SP_VALUE: begin
        if (b != " ") return ST_BAD;
        pst = S_VALUE;
      end
      S_VALUE: begin
        if (b == 8'h0D) begin
          pst = S_NL2;
        end else begin
          if (ctl_char(b)) return ST_BAD;
          feed_length(b);
          cls = CLS_VALUE;
        end
      end
      S_NL2: begin
        if (b != 8'h0A) return ST_BAD;
        pst = S_LINE_START;
      end
      S_NL3: begin
        if (b != 8'h0A) return ST_BAD;
        if (post_match == MM_FULL) begin
          v = len_found ? len_val : '0;
          if (val_phase == VP_NEG && v != 0) return ST_BAD;
          if (v > lim_body) return ST_BAD;
          len_val = v;
          if (v == 0) begin
            pst = S_DONE;
            return ST_COMPLETE;
          end
          pst = S_BODY;
        end else begin
          len_val = '0;
          pst = S_DONE;
          return ST_COMPLETE;
        end
      end
      S_BODY: begin
        if (body_cnt != LEN_SAT) body_cnt = body_cnt + 1'b1;
        if (body_cnt > lim_body) return ST_BAD;
        cls = CLS_BODY;
        return (body_cnt == len_val) ? ST_COMPLETE : ST_NEED;
      end
      default: return ST_BAD;
    endcase
    return ST_NEED;
  endfunction

  function automatic parse_result_t step_parser(input logic nr, input logic [7:0] b);
    parse_result_t r;
    byte_class_t   cls;
    status_t       st;
    if (nr) clear_parser();
    st = final_st;
    cls = CLS_SYNTAX;
    if (st == ST_NEED) begin
      st = parse_byte(b, cls);
      final_st = st;
      if (st == ST_BAD) cls = CLS_SYNTAX;
    end
    r.st = st;
    r.cls = cls;
    r.echo = b;
    r.minor = minor_seen;
    r.post = (post_match == MM_FULL && pst >= S_URI);
    r.length = (pst == S_BODY || pst == S_DONE) ? len_val[23:0] : 24'd0;
    return r;
  endfunction

  // receiver: stall in random bursts while rx_idle is set
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left = stall_left - 1;
      m_tready <= 1'b0;
    end else if (rx_idle && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(0, 18);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    parse_result_t exp_r;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        $error("result item with no expected item pending");
        mismatches++;
      end else begin
        exp_r = pending_results.pop_front();
        check_field("parse_status", 32'(exp_r.st), 32'(m_tdata[1:0]));
        check_field("byte_class", 32'(exp_r.cls), 32'(m_tuser));
        check_field("out_byte", 32'(exp_r.echo), 32'(m_tdata[9:2]));
        check_field("minor_version", 32'(exp_r.minor), 32'(m_tdata[13:10]));
        check_field("is_post", 32'(exp_r.post), 32'(m_tdata[14]));
        check_field("declared_length", 32'(exp_r.length), 32'(m_tdata[38:15]));
      end
    end
  end

  task automatic push_byte(input logic nr, input logic [7:0] b);
    if (tx_idle && $urandom_range(0, 7) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= nr;
    s_tdata <= b;
    do @(posedge clk); while (!s_tready);
    pending_results.insert(pending_results.size(), step_parser(nr, b));
    bytes_sent++;
  endtask

  task automatic send_request();
    for (int i = 0; i < req.size(); i++) push_byte(i == 0, req[i]);
  endtask

  task automatic add_byte(input logic [7:0] c);
    req.insert(req.size(), c);
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endtask

  // hold the sender until every result has come, then let the pipe settle
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_limits(input logic [15:0] head, input logic [23:0] body);
    cfg_we <= 1'b1;
    cfg_index <= CFG_MAX_HEAD;
    cfg_data <= CFG_DATA_W'(head);
    @(posedge clk);
    cfg_index <= CFG_MAX_BODY;
    cfg_data <= body;
    @(posedge clk);
    cfg_we <= 1'b0;
    lim_head = head;
    lim_body = body;
  endtask

  task automatic build_request(input bit faults);
    int unsigned kind, n, v, cut;
    int          len_hint;
    bit          post_req;
    logic [7:0]  c;
    string       s;
    req.delete();
    len_hint = -1;
    kind = $urandom_range(0, 9);
    case (kind)
      0, 1, 2, 3: add_text("POST");
      4, 5: add_text("GET");
      6: add_text("POS");
      7: add_text("POSTS");
      8: add_text("PoST");
      default: begin
        repeat ($urandom_range(1, 5))
          add_byte(token_chars[$urandom_range(0, token_chars.len() - 1)]);
      end
    endcase
    post_req = kind <= 3;
    add_byte(" ");
    n = $urandom_range(0, 6);
    for (int i = 0; i < n; i++) begin
      v = $urandom_range(33, 255);
      add_byte(v == 127 ? "/" : 8'(v));
    end
    add_text($sformatf(" HTTP/1.%0d\r\n", $urandom_range(0, 9)));
    repeat ($urandom_range(0, 2)) begin
      if ($urandom_range(0, 2) == 0) begin
        s = "content-length";
        for (int i = 0; i < s.len(); i++) begin
          c = s[i];
          if (c >= "a" && c <= "z" && $urandom_range(0, 1) == 1) c = c - 8'd32;
          add_byte(c);
        end
        add_text(": ");
        repeat ($urandom_range(0, 2)) add_byte(" ");
        case ($urandom_range(0, 9))
          0: add_byte("-");
          1: add_byte("+");
          default: ;
        endcase
        case ($urandom_range(0, 9))
          0: add_text("98765432109");
          1: add_text($sformatf("%0d", $urandom_range(0, 24'hFF_FFFF)));
          2: add_text("none");
          default: begin
            v = $urandom_range(0, 12);
            add_text($sformatf("%0d", v));
            if (len_hint < 0) len_hint = v;
          end
        endcase
        if ($urandom_range(0, 7) == 0) add_text("x7");
      end else begin
        case ($urandom_range(0, 4))
          0: add_text("Content-Type");
          1: add_text("Content-Len");
          2: add_text("Content-Lengths");
          3: add_text("Host");
          default: add_text("X-id");
        endcase
        add_text(": ");
        n = $urandom_range(0, 6);
        for (int i = 0; i < n; i++) begin
          v = $urandom_range(32, 255);
          add_byte(v == 127 ? "a" : 8'(v));
        end
      end
      // folded continuation line
      if ($urandom_range(0, 5) == 0) begin
        add_text("\r\n");
        add_byte($urandom_range(0, 1) ? 8'h20 : 8'h09);
        add_text($sformatf("%0d", $urandom_range(0, 9)));
      end
      add_text("\r\n");
    end
    add_text("\r\n");
    if (post_req) begin
      n = (len_hint >= 0) ? len_hint + $urandom_range(0, 2) : $urandom_range(0, 5);
      repeat (n) add_byte(8'($urandom_range(0, 255)));
    end
    if (faults && $urandom_range(0, 4) == 0)
      req[$urandom_range(0, req.size() - 1)] = 8'($urandom_range(0, 255));
    if (faults && $urandom_range(0, 9) == 0) begin
      cut = $urandom_range(1, req.size());
      while (req.size() > cut) void'(req.pop_back());
    end
  endtask

  task automatic run_requests(input int unsigned budget, input bit faults);
    int unsigned start;
    start = bytes_sent;
    while (bytes_sent - start < budget) begin
      build_request(faults);
      send_request();
    end
  endtask

  task automatic test_directed();
    req.delete();
    add_text("GET / HTTP/1.9\r\n\r\n");
    send_request();
    push_byte(1'b1, 8'hFF);
    push_byte(1'b0, 8'h00);
    push_byte(1'b1, "P");
    push_byte(1'b0, 8'h80);
    wait_drained();
  endtask

  task automatic test_requests();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    run_requests(600, 1'b1);
    wait_drained();
  endtask

  task automatic test_limits();
    set_limits(16'd1, 24'd0);
    run_requests(40, 1'b0);
    wait_drained();
    set_limits(16'hFFFF, 24'hFF_FFFF);
    run_requests(200, 1'b1);
    wait_drained();
    repeat (3) begin
      set_limits(16'($urandom_range(20, 60)), 24'($urandom_range(0, 8)));
      run_requests(100, 1'b1);
      wait_drained();
    end
    // lower the body limit while a body is still open
    set_limits(16'd8192, 24'd100);
    req.delete();
    add_text("POST / HTTP/1.1\r\nContent-Length: 10\r\n\r\nabc");
    send_request();
    wait_drained();
    set_limits(16'd8192, 24'd2);
    push_byte(1'b0, "d");
    wait_drained();
    // lower the head limit in the middle of the request line
    req.delete();
    add_text("GET / HT");
    send_request();
    wait_drained();
    set_limits(16'd5, 24'd2);
    push_byte(1'b0, "T");
    wait_drained();
  endtask

  task automatic test_noise();
    set_limits(16'd8192, 24'd65536);
    repeat (200) push_byte($urandom_range(0, 9) == 0, 8'($urandom_range(0, 255)));
    wait_drained();
  endtask

  task automatic test_steady();
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    set_limits(16'($urandom_range(60, 400)), 24'($urandom_range(0, 30)));
    run_requests(500, 1'b1);
  endtask

  initial begin
    clear_parser();
    lim_head = 16'd8192;
    lim_body = 24'd65536;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_requests();
    test_limits();
    test_noise();
    test_steady();
    wait_drained();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end

endmodule

/* filelist.f */
rtl/hrp_pkg.sv
rtl/hrp_core.sv
rtl/http_request_parser.sv
dv/tb.sv
